FILE: design/temperature_scratchpad_crc_decoder_macros.svh
// ----------------------------------------------------------------------------
// temperature scratchpad crc decoder assertion macros
// concurrent assertion helpers used by the top-level decoder
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_SCRATCHPAD_CRC_DECODER_MACROS_SVH
`define TEMPERATURE_SCRATCHPAD_CRC_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TSCD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TSCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tscd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscd_pkg
// shared types, constants and the crc-8 step for the scratchpad decoder
// ----------------------------------------------------------------------------
package tscd_pkg;

    localparam logic [7:0]  CRC_POLY      = 8'h8C;
    localparam logic [3:0]  LAST_POSITION = 4'd8;
    localparam logic [15:0] POS_SPLIT     = 16'd2000;
    // 625/10 reduced to 125/2 so the halving is a plain shift
    localparam logic [31:0] POS_MUL       = 32'd125;
    localparam logic [15:0] NEG_OFFSET    = 16'hFFFF;
    localparam logic [31:0] NEG_MUL       = 32'(55 * 1000);
    // divide by 879 as a multiply by 2^41/879 rounded up and a shift by 41;
    // the rounding error stays below one step for any numerator under 2^32
    localparam logic [31:0] NEG_RECIP     = 32'd2501732942;
    localparam int          NEG_SHIFT     = 41;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    localparam int TEMP_W = 23;

    typedef struct packed {
        logic [15:0] raw;
        logic [7:0]  crc;
        logic        ok;
    } tscd_frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tscd_fifo_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // one byte of the reflected crc-8, lsb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/tscd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscd_front
// byte intake: position count, running crc, raw capture, frame push
// ----------------------------------------------------------------------------
module tscd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire tscd_pkg::tscd_fifo_status_t   fifo_stat,
    output logic                               push,
    output tscd_pkg::tscd_frame_t              push_data
);
    import tscd_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] lo_reg, lo_next;
    logic [7:0] hi_reg, hi_next;
    logic       last;
    logic       accept;

    // anything at or past the ninth position closes the frame
    assign last    = (pos_reg >= LAST_POSITION);
    assign s_ready = !last || !fifo_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && last;

    assign push_data.raw = {hi_reg, lo_reg};
    assign push_data.crc = crc_reg;
    assign push_data.ok  = (crc_reg == s_data_byte);

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (accept) begin
            if (last) begin
                pos_next = '0;
                crc_next = '0;
            end else begin
                pos_next = pos_reg + 4'd1;
                crc_next = crc8_update(crc_reg, s_data_byte);
                if (pos_reg == 4'd0) begin
                    lo_next = s_data_byte;
                end
                if (pos_reg == 4'd1) begin
                    hi_next = s_data_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/tscd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscd_fifo
// small frame queue between intake and arithmetic
// ----------------------------------------------------------------------------
module tscd_fifo #(
    parameter int DEPTH = tscd_pkg::FIFO_DEPTH_DEFAULT  // two or more
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire tscd_pkg::tscd_frame_t       push_data,
    input  wire logic                        pop,
    output tscd_pkg::tscd_frame_t            rd_data,
    output tscd_pkg::tscd_fifo_status_t      stat
);
    import tscd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tscd_frame_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/tscd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscd_back
// temperature arithmetic: scale multiply, reciprocal divide by 879, output register
// ----------------------------------------------------------------------------
module tscd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tscd_pkg::tscd_fifo_status_t   fifo_stat,
    input  wire tscd_pkg::tscd_frame_t         rd_data,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [tscd_pkg::TEMP_W-1:0] m_temperature_milli,
    output logic                               m_crc_ok,
    output logic [7:0]                         m_crc_value
);
    import tscd_pkg::*;

    back_state_t          state_reg, state_next;
    logic [15:0]          raw_reg, raw_next;
    logic [7:0]           crc_reg, crc_next;
    logic                 ok_reg, ok_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          n_reg, n_next;

    logic                 m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;
    logic                 ok_out_reg, ok_out_next;
    logic [7:0]           crc_out_reg, crc_out_next;

    logic [15:0]          diff;
    logic [63:0]          prod;
    logic [63-NEG_SHIFT:0] quot;
    logic                 load;

    assign diff = NEG_OFFSET - raw_reg;
    assign prod = {32'd0, n_reg} * {32'd0, NEG_RECIP};
    assign quot = prod[63:NEG_SHIFT];

    always_comb begin
        state_next   = state_reg;
        raw_next     = raw_reg;
        crc_next     = crc_reg;
        ok_next      = ok_reg;
        neg_next     = neg_reg;
        n_next       = n_reg;
        pop          = 1'b0;
        load         = 1'b0;
        temp_next    = temp_reg;
        ok_out_next  = ok_out_reg;
        crc_out_next = crc_out_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!fifo_stat.empty) begin
                    pop        = 1'b1;
                    raw_next   = rd_data.raw;
                    crc_next   = rd_data.crc;
                    ok_next    = rd_data.ok;
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                neg_next = (raw_reg >= POS_SPLIT);
                if (raw_reg >= POS_SPLIT) begin
                    n_next = 32'(diff) * NEG_MUL;
                end else begin
                    n_next = 32'(raw_reg) * POS_MUL;
                end
                state_next = (ok_reg && (raw_reg >= POS_SPLIT)) ? BK_DIV : BK_DONE;
            end
            BK_DIV: begin
                // quotient by 879 from the reciprocal product
                n_next     = 32'(quot);
                state_next = BK_DONE;
            end
            BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load         = 1'b1;
                    ok_out_next  = ok_reg;
                    crc_out_next = crc_reg;
                    if (!ok_reg) begin
                        temp_next = '0;
                    end else if (neg_reg) begin
                        temp_next = TEMP_W'(0) - n_reg[TEMP_W-1:0];
                    end else begin
                        temp_next = n_reg[TEMP_W:1];
                    end
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        crc_reg     <= crc_next;
        ok_reg      <= ok_next;
        neg_reg     <= neg_next;
        n_reg       <= n_next;
        temp_reg    <= temp_next;
        ok_out_reg  <= ok_out_next;
        crc_out_reg <= crc_out_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_milli = temp_reg;
    assign m_crc_ok            = ok_out_reg;
    assign m_crc_value         = crc_out_reg;

endmodule
`default_nettype wire

FILE: design/temperature_scratchpad_crc_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_scratchpad_crc_decoder
// nine-byte sensor scratchpad in, crc check and milli-degree temperature out
// ----------------------------------------------------------------------------
// usage:
//   s_valid/s_ready/s_data_byte carries scratchpad bytes, byte 0 first, one
//   byte per transfer. bytes 0 to 7 feed a reflected crc-8 (0x8c); the ninth
//   byte is compared with it and closes the frame.
//   m_valid/m_ready carries one result per frame: crc flag, computed crc and
//   the temperature in milli-degrees (forced to zero when the crc fails).
//   after the ninth byte, a frame passes the queue, BK_IDLE, BK_MUL and
//   BK_DONE before m_valid rises for readings below 2000 counts or a failed
//   crc; the upper (negative) range also passes BK_DIV, whose reciprocal
//   multiply divides by 879. bytes are taken one per cycle unless a full
//   queue holds the ninth byte; the back end uses fewer states per frame
//   than 9 byte transfers, so bytes flow on while the receiver takes results.
//   a frame queue (FIFO_DEPTH entries, two or more) sits between the byte
//   front end and the arithmetic, and the result sits in an output register,
//   so a stalled receiver only holds s_ready low on a ninth byte once the
//   queue has filled up.
//   reset (aresetn low, synchronous) returns to byte 0 with a zero crc and
//   drops any queued or pending result.
// ----------------------------------------------------------------------------
`include "temperature_scratchpad_crc_decoder_macros.svh"

module temperature_scratchpad_crc_decoder #(
    parameter int FIFO_DEPTH = tscd_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // byte input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [tscd_pkg::TEMP_W-1:0] m_temperature_milli,
    output logic                               m_crc_ok,
    output logic [7:0]                         m_crc_value
);
    import tscd_pkg::*;

    // frame hand-off between the front end and the queue
    logic              push;
    tscd_frame_t       push_data;
    // queue to back end
    logic              pop;
    tscd_frame_t       rd_data;
    tscd_fifo_status_t fifo_stat;

    // byte intake and crc
    tscd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .fifo_stat   (fifo_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // completed frames waiting for the arithmetic
    tscd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .stat      (fifo_stat)
    );

    // temperature conversion and output register
    tscd_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .fifo_stat           (fifo_stat),
        .rd_data             (rd_data),
        .pop                 (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_milli (m_temperature_milli),
        .m_crc_ok            (m_crc_ok),
        .m_crc_value         (m_crc_value)
    );

    // a frame is never pushed into a full queue
    `TSCD_ASSERT_NOW(a_push_not_full, aclk, aresetn, push, !fifo_stat.full, "push into full queue")
    // the back end never pops an empty queue
    `TSCD_ASSERT_NOW(a_pop_not_empty, aclk, aresetn, pop, !fifo_stat.empty, "pop from empty queue")
    // a failed crc always reports a zero temperature
    `TSCD_ASSERT_NOW(a_bad_crc_zero, aclk, aresetn, m_valid && !m_crc_ok,
        m_temperature_milli == '0, "temperature not zero on crc failure")
    // a pushed frame shows the queue non-empty on the next cycle
    `TSCD_ASSERT_NEXT(a_push_visible, aclk, aresetn, push && !pop, !fifo_stat.empty,
        "pushed frame lost")

endmodule
`default_nettype wire

FILE: sim/scratchpad_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scratchpad reading checker
// follows every byte transfer into the decoder, predicts the reading that
// each closed frame yields and compares it with the result transfers
// ----------------------------------------------------------------------------
module scratchpad_reading_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [tscd_pkg::TEMP_W-1:0] m_temperature_milli,
    input  logic                               m_crc_ok,
    input  logic [7:0]                         m_crc_value,
    output int                                 mismatches,
    output int                                 readings_due
);

    typedef struct packed {
        logic [tscd_pkg::TEMP_W-1:0] milli;
        logic                        ok;
        logic [7:0]                  crc;
    } reading_t;

    reading_t   due_readings[$];
    logic [3:0] frame_pos;
    logic [7:0] frame_crc;
    logic [7:0] raw_lo;
    logic [7:0] raw_hi;

    initial mismatches = 0;
    initial readings_due = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns checker: %s", $time, what);
        mismatches++;
    endtask

    // reflected crc-8, one data bit per feedback step, lsb first
    function automatic logic [7:0] crc_after(input logic [7:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) acc = acc ^ tscd_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    // wide signed arithmetic, division truncates toward zero
    function automatic logic [tscd_pkg::TEMP_W-1:0] milli_of(input logic [15:0] raw);
        longint r;
        longint t;
        r = longint'({48'd0, raw});
        if (r < 2000) t = (625 * r) / 10;
        else t = ((r - 65535) * 55 * 1000) / 879;
        return t[tscd_pkg::TEMP_W-1:0];
    endfunction

    task automatic take_byte(input logic [7:0] b);
        reading_t r;
        if (frame_pos < tscd_pkg::LAST_POSITION) begin
            if (frame_pos == 4'd0) raw_lo = b;
            else if (frame_pos == 4'd1) raw_hi = b;
            frame_crc = crc_after(frame_crc, b);
            frame_pos = frame_pos + 4'd1;
        end else begin
            r.ok    = (frame_crc == b);
            r.crc   = frame_crc;
            r.milli = r.ok ? milli_of({raw_hi, raw_lo}) : '0;
            due_readings.push_back(r);
            frame_pos = '0;
            frame_crc = '0;
        end
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            frame_pos = '0;
            frame_crc = '0;
            raw_lo    = '0;
            raw_hi    = '0;
            due_readings.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_readings.size() == 0) begin
                    report_mismatch("result transfer with no reading due");
                end else begin
                    want = due_readings.pop_front();
                    if (m_temperature_milli !== want.milli)
                        report_mismatch($sformatf("temperature %0d, want %0d",
                            m_temperature_milli, $signed(want.milli)));
                    if (m_crc_ok !== want.ok)
                        report_mismatch($sformatf("crc flag %0b, want %0b",
                            m_crc_ok, want.ok));
                    if (m_crc_value !== want.crc)
                        report_mismatch($sformatf("crc value %02h, want %02h",
                            m_crc_value, want.crc));
                end
            end
            if (s_valid && s_ready) take_byte(s_data_byte);
        end
        readings_due = due_readings.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scratchpad crc decoder testbench
// feeds nine-byte scratchpad frames, directed corners first and then mostly
// well-formed random frames with some corrupted crcs and raw noise, with
// random idling on both channels, a long receiver hold-off and drain pauses;
// the checker beside the block predicts and compares every reading
// ----------------------------------------------------------------------------
module tb;

    localparam int BYTE_TARGET = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 60;

    logic                               aclk        = 1'b0;
    logic                               aresetn     = 1'b0;
    logic                               s_valid     = 1'b0;
    logic                               s_ready;
    logic [7:0]                         s_data_byte = 8'd0;
    logic                               m_valid;
    logic                               m_ready     = 1'b0;
    logic signed [tscd_pkg::TEMP_W-1:0] m_temperature_milli;
    logic                               m_crc_ok;
    logic [7:0]                         m_crc_value;

    int mismatches;
    int readings_due;
    int cycle_count = 0;
    int bytes_sent  = 0;
    // shared between the stimulus and the receiver: no-idle stretches and
    // a one-off long hold-off request
    bit no_idle     = 1'b0;
    int rx_hold     = 0;

    always #2 aclk = ~aclk;

    temperature_scratchpad_crc_decoder dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_milli (m_temperature_milli),
        .m_crc_ok            (m_crc_ok),
        .m_crc_value         (m_crc_value)
    );

    scratchpad_reading_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_milli (m_temperature_milli),
        .m_crc_ok            (m_crc_ok),
        .m_crc_value         (m_crc_value),
        .mismatches          (mismatches),
        .readings_due        (readings_due)
    );

    // synchronous reset, released once at the start and never asserted again
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // crc of the frame body, needed to build frames that pass the check
    function automatic logic [7:0] frame_crc_of(input logic [7:0] body [8]);
        logic [7:0] c;
        c = 8'd0;
        for (int j = 0; j < 8; j++) begin
            c = c ^ body[j];
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ tscd_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // one byte transfer; valid only drops when a gap is drawn, so a
    // back-to-back transfer never lowers and raises it in the same step
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // bytes 0 and 1 carry the raw reading, 2 to 7 come from fill, and the
    // ninth byte is the crc, flipped in some bits when spoil is set
    task automatic send_frame(input logic [15:0] raw, input logic [47:0] fill, input bit spoil);
        logic [7:0] body [8];
        logic [7:0] tail;
        body[0] = raw[7:0];
        body[1] = raw[15:8];
        for (int j = 2; j < 8; j++) body[j] = fill[8*(j-2) +: 8];
        tail = frame_crc_of(body);
        if (spoil) tail = tail ^ 8'($urandom_range(1, 255));
        for (int j = 0; j < 8; j++) send_byte(body[j]);
        send_byte(tail);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1999;    // top of the positive branch
            2:       return 16'd2000;    // first value of the negative branch
            3:       return 16'hFFFF;
            4:       return 16'hFFFE;
            5, 6:    return 16'($urandom_range(0, 1999));
            7, 8:    return 16'($urandom_range(2000, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // receiver: random ready gaps, plus one long hold-off counted here so
    // the frame queue fills and the block stalls its byte input
    initial begin
        int gap;
        int hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                hold    = rx_hold;
                rx_hold = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else begin
                gap = idle_cycles();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int frame_idx;
        while (!aresetn) @(posedge aclk);

        // directed: all-zero frame, all-ones frame, crc mismatch at the
        // top of the positive range
        send_frame(16'd0, 48'd0, 1'b0);
        send_frame(16'hFFFF, {48{1'b1}}, 1'b0);
        send_frame(16'd1999, 48'({$urandom, $urandom}), 1'b1);

        frame_idx = 0;
        while (bytes_sent < BYTE_TARGET) begin
            // stretches with no idling on either side
            no_idle = (frame_idx >= 30 && frame_idx < 37) || (frame_idx >= 70 && frame_idx < 80);
            // receiver holds off while the sender keeps offering frames
            if (frame_idx == 30) rx_hold = LONG_HOLD;
            // sender pauses until every reading has come out; the first
            // cycle lets the checker take the last byte transfer
            if (frame_idx == 50 || $urandom_range(0, 24) == 0) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (readings_due != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 99) < 85) begin
                send_frame(pick_raw(), 48'({$urandom, $urandom}), $urandom_range(0, 4) == 0);
            end else begin
                // raw noise: nine arbitrary bytes, almost always a bad crc
                repeat (9) send_byte(8'($urandom_range(0, 255)));
            end
            frame_idx++;
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (readings_due != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && readings_due == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
